FILE: src/segment_tree_sqrt_sum_core_macros.svh
// Assertion macros for the segment tree sum core.
`ifndef SEGMENT_TREE_SQRT_SUM_CORE_MACROS_SVH
`define SEGMENT_TREE_SQRT_SUM_CORE_MACROS_SVH

// Implication checked every clock, quiet during reset.
`define STS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, quiet during reset.
`define STS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: src/sts_pkg.sv
// Package: constants, types and state codes for the segment tree sum core.
`timescale 1ns / 1ps
package sts_pkg;
  localparam int MaxPositions = 1024;
  localparam int IdxW = $clog2(MaxPositions);      // position within leaves
  localparam int NodeW = IdxW + 1;                 // node address
  localparam int CntW = 11;
  localparam int ValW = 54;
  localparam int SumW = 64;
  localparam int OpW = 2;

  localparam logic [OpW-1:0] OP_LOAD = 2'd0;
  localparam logic [OpW-1:0] OP_ROOT = 2'd1;
  localparam logic [OpW-1:0] OP_QUERY = 2'd2;
  localparam logic [OpW-1:0] OP_UNUSED = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_LD_WR,
    ST_UP_RD_A,
    ST_UP_RD_B,
    ST_UP_WR,
    ST_RT_RD,
    ST_RT_CHK,
    ST_RT_ITER,
    ST_Q_STEP,
    ST_Q_WAIT_L,
    ST_Q_WAIT_R,
    ST_OUT
  } state_t;
endpackage

FILE: src/sts_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module sts_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

FILE: src/segment_tree_sqrt_sum_core.sv
// Top level: segment tree of 64-bit partial sums with load, range root and range sum.
`timescale 1ns / 1ps
// One word at a time. The tree lives in a single-port RAM of 2*MaxPositions
// words (node 1 is the root, leaf of position p is node MaxPositions+p-1), and
// every operation is sequenced over that one port, so the port sets the rate.
// After reset a clearing pass writes zero to all 2*MaxPositions nodes before
// the first word is taken; count_in_use writes are taken at any time.
// A load writes the leaf, then reads both children and writes the parent per
// level. A query walks the standard bottom-up range loop, one node read per
// step, about 2*log2(MaxPositions) reads at most. A range root visits each
// leaf in range: a leaf at 0 or 1 is skipped; otherwise the shared root unit
// runs 27 two-bit steps, then the leaf path is refreshed as for a load. The
// root uses the digit-by-digit method on one shared subtract/compare
// datapath. Operation 3 is taken and dropped. Only a query returns a word on
// range_sum.
module segment_tree_sqrt_sum_core
  import sts_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CntW-1:0]   cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [OpW-1:0]    operation,
  input  logic [CntW-1:0]   first_index,
  input  logic [CntW-1:0]   second_index,
  input  logic [ValW-1:0]   value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [SumW-1:0]   range_sum
);
`include "segment_tree_sqrt_sum_core_macros.svh"

  localparam logic [CntW-1:0] MaxCnt = CntW'(MaxPositions);
  localparam int RootSteps = (ValW + 1) / 2;

  state_t state, state_next;

  logic [CntW-1:0]  count_in_use;
  logic [NodeW-1:0] node, node_next;        // current node / loop left bound
  logic [NodeW:0]   rnode, rnode_next;      // query right bound (exclusive)
  logic [CntW-1:0]  pos, pos_next;          // current root position
  logic [CntW-1:0]  hi, hi_next;
  logic [SumW-1:0]  acc, acc_next;          // leaf value, left child sum or query sum
  logic [SumW-1:0]  sum_out, sum_out_next;
  logic             out_v, out_v_next;
  logic             root_mode, root_mode_next;
  logic             rpend, rpend_next;      // right read pending in query

  // shared root unit registers
  logic [ValW-1:0]  rx, rx_next;
  logic [ValW-1:0]  rres, rres_next;
  logic [ValW-1:0]  rbit, rbit_next;

  // RAM port
  logic             ram_we;
  logic [NodeW-1:0] ram_addr;
  logic [SumW-1:0]  ram_wdata, ram_rdata;

  sts_ram #(.Width(SumW), .Depth(2 * MaxPositions)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // clipped range of the incoming word
  logic [CntW-1:0] act_n, lo_c, hi_c, a_s, b_s;
  logic            rng_ok, ld_ok;
  always_comb begin
    act_n = (count_in_use > MaxCnt) ? MaxCnt : count_in_use;
    a_s = (first_index > second_index) ? second_index : first_index;
    b_s = (first_index > second_index) ? first_index : second_index;
    lo_c = (a_s < CntW'(1)) ? CntW'(1) : a_s;
    hi_c = (b_s > act_n) ? act_n : b_s;
    rng_ok = (lo_c <= hi_c);
    ld_ok = (first_index >= CntW'(1)) && (first_index <= act_n);
  end

  function automatic logic [NodeW-1:0] leaf_of(input logic [CntW-1:0] p);
    logic [CntW:0] t;
    t = (CntW + 1)'(MaxPositions) + (CntW + 1)'(p) - (CntW + 1)'(1);
    return t[NodeW-1:0];
  endfunction

  // root step: one trial subtract
  logic [ValW:0]   trial;
  logic            ge;
  assign trial = {1'b0, rres} + {1'b0, rbit};
  assign ge = ({1'b0, rx} >= trial);

  logic [NodeW:0] lnode_w;
  assign lnode_w = {1'b0, node};

  always_comb begin
    state_next = state;
    node_next = node;
    rnode_next = rnode;
    pos_next = pos;
    hi_next = hi;
    acc_next = acc;
    sum_out_next = sum_out;
    out_v_next = out_v;
    root_mode_next = root_mode;
    rpend_next = rpend;
    rx_next = rx;
    rres_next = rres;
    rbit_next = rbit;
    ram_we = 1'b0;
    ram_addr = node;
    ram_wdata = '0;
    in_ready = 1'b0;

    if (out_v && out_ready) begin
      out_v_next = 1'b0;
    end

    case (state)
      ST_CLEAR: begin
        ram_we = 1'b1;
        ram_addr = node;
        ram_wdata = '0;
        node_next = node + NodeW'(1);
        if (node == '1) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          root_mode_next = 1'b0;
          case (operation)
            OP_LOAD: begin
              if (ld_ok) begin
                node_next = leaf_of(first_index);
                acc_next = SumW'(value);
                state_next = ST_LD_WR;
              end
            end
            OP_ROOT: begin
              if (rng_ok) begin
                pos_next = lo_c;
                hi_next = hi_c;
                root_mode_next = 1'b1;
                state_next = ST_RT_RD;
              end
            end
            OP_QUERY: begin
              acc_next = '0;
              rpend_next = 1'b0;
              if (rng_ok) begin
                node_next = leaf_of(lo_c);
                rnode_next = (NodeW + 1)'(leaf_of(hi_c)) + (NodeW + 1)'(1);
                state_next = ST_Q_STEP;
              end else begin
                state_next = ST_OUT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_LD_WR: begin
        // write leaf (acc holds value), then climb
        ram_we = 1'b1;
        ram_addr = node;
        ram_wdata = acc;
        state_next = ST_UP_RD_A;
      end
      ST_UP_RD_A: begin
        if (node == NodeW'(1)) begin
          if (root_mode && pos != hi) begin
            pos_next = pos + CntW'(1);
            state_next = ST_RT_RD;
          end else begin
            state_next = ST_IDLE;
          end
        end else begin
          ram_addr = {node[NodeW-1:1], 1'b0};
          state_next = ST_UP_RD_B;
        end
      end
      ST_UP_RD_B: begin
        acc_next = ram_rdata;
        ram_addr = {node[NodeW-1:1], 1'b1};
        state_next = ST_UP_WR;
      end
      ST_UP_WR: begin
        ram_we = 1'b1;
        ram_addr = {1'b0, node[NodeW-1:1]};
        ram_wdata = acc + ram_rdata;
        node_next = {1'b0, node[NodeW-1:1]};
        state_next = ST_UP_RD_A;
      end
      ST_RT_RD: begin
        ram_addr = leaf_of(pos);
        node_next = leaf_of(pos);
        state_next = ST_RT_CHK;
      end
      ST_RT_CHK: begin
        if (ram_rdata > SumW'(1)) begin
          rx_next = ram_rdata[ValW-1:0];
          rres_next = '0;
          rbit_next = ValW'(1) << (2 * (RootSteps - 1));
          state_next = ST_RT_ITER;
        end else if (pos != hi) begin
          pos_next = pos + CntW'(1);
          state_next = ST_RT_RD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_RT_ITER: begin
        if (ge) begin
          rx_next = rx - trial[ValW-1:0];
          rres_next = (rres >> 1) + rbit;
        end else begin
          rres_next = rres >> 1;
        end
        rbit_next = rbit >> 2;
        if (rbit == ValW'(1)) begin
          acc_next = ge ? SumW'((rres >> 1) + rbit) : SumW'(rres >> 1);
          state_next = ST_LD_WR;
        end
      end
      ST_Q_STEP: begin
        // absorb the pending right read
        if (rpend) begin
          acc_next = acc + ram_rdata;
          rpend_next = 1'b0;
        end
        if (lnode_w >= rnode) begin
          state_next = rpend ? ST_Q_STEP : ST_OUT;
          if (rpend) begin
            state_next = ST_OUT;
          end
        end else if (node[0]) begin
          ram_addr = node;
          node_next = node + NodeW'(1);
          state_next = ST_Q_WAIT_L;
        end else if (rnode[0]) begin
          ram_addr = NodeW'(rnode - (NodeW + 1)'(1));
          rnode_next = rnode - (NodeW + 1)'(1);
          state_next = ST_Q_WAIT_R;
        end else begin
          node_next = node >> 1;
          rnode_next = rnode >> 1;
        end
      end
      ST_Q_WAIT_L: begin
        acc_next = acc + ram_rdata;
        if (rnode[0]) begin
          ram_addr = NodeW'(rnode - (NodeW + 1)'(1));
          rnode_next = rnode - (NodeW + 1)'(1);
          state_next = ST_Q_WAIT_R;
        end else begin
          node_next = node >> 1;
          rnode_next = rnode >> 1;
          state_next = ST_Q_STEP;
        end
      end
      ST_Q_WAIT_R: begin
        acc_next = acc + ram_rdata;
        node_next = node >> 1;
        rnode_next = rnode >> 1;
        state_next = ST_Q_STEP;
      end
      ST_OUT: begin
        if (!out_v || out_ready) begin
          sum_out_next = acc;
          out_v_next = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      node <= '0;
      out_v <= 1'b0;
      count_in_use <= MaxCnt;
      rpend <= 1'b0;
      root_mode <= 1'b0;
    end else begin
      state <= state_next;
      node <= node_next;
      out_v <= out_v_next;
      rpend <= rpend_next;
      root_mode <= root_mode_next;
      if (cfg_we) begin
        count_in_use <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    rnode <= rnode_next;
    pos <= pos_next;
    hi <= hi_next;
    acc <= acc_next;
    sum_out <= sum_out_next;
    rx <= rx_next;
    rres <= rres_next;
    rbit <= rbit_next;
  end

  assign out_valid = out_v;
  assign range_sum = sum_out;

  `STS_ASSERT_IMPL(a_ready_idle, in_ready, state == ST_IDLE)
  `STS_ASSERT_NEXT(a_hold_out, out_v && !out_ready, out_v && $stable(sum_out))
  `STS_ASSERT_IMPL(a_root_range, state == ST_RT_RD, pos <= hi)
  `STS_ASSERT_IMPL(a_no_write_query, state == ST_Q_STEP || state == ST_Q_WAIT_L, !ram_we)
endmodule
